FILE: sv/orl_pkg.sv
// ----------------------------------------------------------------------------
// orl_pkg
// Shared sizes, codes, types and the command/status bundles that join the
// controller and the datapath of the ordered record list.
// ----------------------------------------------------------------------------
package orl_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 2;
    localparam int POS_W   = 8;
    localparam int ID_W    = 16;
    localparam int MARK_W  = 12;
    localparam int TOTAL_W = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int AVG_W   = 12;
    localparam int REC_W   = ID_W + MARK_W;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int STEP_W  = $clog2(TOTAL_W);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [OP_W-1:0]    op_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [MARK_W-1:0]  mark_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [COUNT_W-1:0] count_port_t;
    typedef logic [AVG_W-1:0]   avg_t;
    typedef logic [REC_W-1:0]   rec_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [STEP_W-1:0]  step_t;

    localparam op_t OP_INS_FRONT = 2'd0;
    localparam op_t OP_INS_POS   = 2'd1;
    localparam op_t OP_DEL_LAST  = 2'd2;
    localparam op_t OP_QUERY     = 2'd3;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BADPOS = 2'd1;
    localparam status_t ST_EMPTY  = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval;
        logic load_ptr;
        logic shift_rd;
        logic place;
        logic del_rd;
        logic del_upd;
        logic div_start;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_ok;
        logic del_ok;
        logic ptr_above;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

FILE: sv/ordered_record_list.sv
// ----------------------------------------------------------------------------
// ordered_record_list
// Ordered list of up to 16 records (id and mark) with a running mark total;
// every item returns a status, the record count and the truncated mean mark.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one operation per item:
// insert at the front, insert at a 1-based position, delete the last record
// or query. The output channel (out_valid, out_stall) returns one result item
// for each input item, in order.
// One item is worked on at a time. An insert moves each record behind its
// slot one place back, one record per cycle through the single read port of
// the record store, before it places the new record; every item then runs
// the mean divider before its result is handed over.
// The result sits in an output register, so the next item can be accepted
// while a result still waits. If the receiver stalls, the finished item
// after that waits in the controller and in_stall stays high.
// Reset empties the list and clears the total; no clearing pass is needed,
// since only records below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_record_list (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  orl_pkg::op_t         operation,
    input  orl_pkg::pos_t        position,
    input  orl_pkg::id_t         entry_id,
    input  orl_pkg::mark_t       entry_marks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output orl_pkg::status_t     status,
    output orl_pkg::count_port_t entry_count,
    output orl_pkg::avg_t        average_marks
);

    orl_pkg::cmd_t  cmd;
    orl_pkg::stat_t stat;

    orl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    orl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .position      (position),
        .entry_id      (entry_id),
        .entry_marks   (entry_marks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_count   (entry_count),
        .average_marks (average_marks)
    );

endmodule

FILE: sv/orl_ram.sv
// ----------------------------------------------------------------------------
// orl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module orl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/orl_div.sv
// ----------------------------------------------------------------------------
// orl_div
// Restoring divider, one quotient bit per cycle, for the mean of the marks.
// ----------------------------------------------------------------------------
module orl_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  orl_pkg::total_t dividend,
    input  orl_pkg::cnt_t   divisor,
    output logic            done,
    output orl_pkg::total_t quotient
);

    localparam orl_pkg::step_t LAST_STEP = orl_pkg::step_t'(orl_pkg::TOTAL_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    orl_pkg::step_t                step_reg;
    orl_pkg::cnt_t                 rem_reg;
    orl_pkg::cnt_t                 rem_next;
    orl_pkg::cnt_t                 dvs_reg;
    orl_pkg::total_t               quo_reg;
    logic [orl_pkg::CNT_W:0]       trial;
    logic [orl_pkg::CNT_W:0]       dvs_ext;
    logic                          qbit;

    assign trial   = {rem_reg, quo_reg[orl_pkg::TOTAL_W-1]};
    assign dvs_ext = {1'b0, dvs_reg};
    assign qbit    = (trial >= dvs_ext);

    // The remainder stays below the divisor, so it fits the count width.
    always_comb
    begin
        if (qbit)
        begin
            rem_next = orl_pkg::cnt_t'(trial - dvs_ext);
        end
        else
        begin
            rem_next = orl_pkg::cnt_t'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[orl_pkg::TOTAL_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/orl_dp.sv
// ----------------------------------------------------------------------------
// orl_dp
// Datapath: item registers, record store, count and running total, divider
// and the result register.
// ----------------------------------------------------------------------------
module orl_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  orl_pkg::cmd_t        cmd,
    output orl_pkg::stat_t       stat,
    input  orl_pkg::op_t         operation,
    input  orl_pkg::pos_t        position,
    input  orl_pkg::id_t         entry_id,
    input  orl_pkg::mark_t       entry_marks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output orl_pkg::status_t     status,
    output orl_pkg::count_port_t entry_count,
    output orl_pkg::avg_t        average_marks
);

    // Item registers.
    orl_pkg::op_t         op_reg;
    orl_pkg::pos_t        pos_reg;
    orl_pkg::id_t         id_reg;
    orl_pkg::mark_t       mark_reg;

    // List state.
    orl_pkg::cnt_t        count_reg;
    orl_pkg::total_t      total_reg;
    orl_pkg::status_t     status_reg;
    orl_pkg::cnt_t        ptr_reg;
    logic                 pend_reg;
    orl_pkg::idx_t        pend_addr_reg;

    // Result register.
    logic                 out_valid_reg;
    orl_pkg::status_t     out_status_reg;
    orl_pkg::count_port_t out_count_reg;
    orl_pkg::avg_t        out_avg_reg;

    logic                 is_full;
    logic                 is_empty;
    logic                 pos_bad;
    orl_pkg::cnt_t        slot;
    orl_pkg::status_t     status_calc;
    orl_pkg::cnt_t        rd_ptr;
    orl_pkg::idx_t        raddr;
    logic                 we;
    orl_pkg::idx_t        waddr;
    orl_pkg::rec_t        wdata;
    orl_pkg::rec_t        rdata;
    orl_pkg::mark_t       rd_mark;
    logic                 div_done;
    orl_pkg::total_t      quotient;

    assign is_full  = (count_reg == orl_pkg::cnt_t'(orl_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (pos_reg == '0) ||
                      (orl_pkg::cmp_t'(pos_reg) > (orl_pkg::cmp_t'(count_reg) + 1'b1));
    assign slot     = (op_reg == orl_pkg::OP_INS_POS) ?
                      orl_pkg::cnt_t'(pos_reg - 1'b1) : '0;

    always_comb
    begin
        unique case (op_reg)
            orl_pkg::OP_INS_FRONT:
                status_calc = is_full ? orl_pkg::ST_FULL : orl_pkg::ST_OK;
            orl_pkg::OP_INS_POS:
                status_calc = pos_bad ? orl_pkg::ST_BADPOS :
                              (is_full ? orl_pkg::ST_FULL : orl_pkg::ST_OK);
            orl_pkg::OP_DEL_LAST:
                status_calc = is_empty ? orl_pkg::ST_EMPTY : orl_pkg::ST_OK;
            default:
                status_calc = is_empty ? orl_pkg::ST_EMPTY : orl_pkg::ST_OK;
        endcase
    end

    assign stat.ins_ok    = (status_calc == orl_pkg::ST_OK) &&
                            ((op_reg == orl_pkg::OP_INS_FRONT) ||
                             (op_reg == orl_pkg::OP_INS_POS));
    assign stat.del_ok    = (op_reg == orl_pkg::OP_DEL_LAST) && !is_empty;
    assign stat.ptr_above = (ptr_reg > slot);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // A delete reads the last record; a shift step reads the one below the pointer.
    assign rd_ptr = cmd.del_rd ? count_reg : ptr_reg;
    assign raddr  = orl_pkg::idx_t'(rd_ptr - 1'b1);

    // The record read in one shift step is written one place back in the next
    // cycle. The new record is placed only after the last such write.
    assign we    = pend_reg || cmd.place;
    assign waddr = pend_reg ? pend_addr_reg : orl_pkg::idx_t'(slot);
    assign wdata = pend_reg ? rdata : {id_reg, mark_reg};

    assign rd_mark = rdata[orl_pkg::MARK_W-1:0];

    orl_ram #(
        .WIDTH (orl_pkg::REC_W),
        .DEPTH (orl_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    orl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= operation;
            pos_reg  <= position;
            id_reg   <= entry_id;
            mark_reg <= entry_marks;
        end
        if (cmd.eval)
        begin
            status_reg <= status_calc;
        end
        if (cmd.load_ptr)
        begin
            ptr_reg <= count_reg;
        end
        else if (cmd.shift_rd)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (cmd.shift_rd)
        begin
            pend_addr_reg <= orl_pkg::idx_t'(ptr_reg);
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= orl_pkg::count_port_t'(count_reg);
            out_avg_reg    <= is_empty ? '0 : orl_pkg::avg_t'(quotient);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.shift_rd;
            if (cmd.place)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + orl_pkg::total_t'(mark_reg);
            end
            else if (cmd.del_upd)
            begin
                count_reg <= count_reg - 1'b1;
                total_reg <= total_reg - orl_pkg::total_t'(rd_mark);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign average_marks = out_avg_reg;

endmodule

FILE: sv/orl_ctrl.sv
// ----------------------------------------------------------------------------
// orl_ctrl
// Controller: sequences one item through decode, record shifting, update,
// division and hand-over to the result register.
// ----------------------------------------------------------------------------
module orl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  orl_pkg::stat_t stat,
    output orl_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_DELW   = 3'd4;
    localparam logic [2:0] S_DIVGO  = 3'd5;
    localparam logic [2:0] S_DIVRUN = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.eval = 1'b1;
                if (stat.ins_ok)
                begin
                    cmd.load_ptr = 1'b1;
                    state_next   = S_SHIFT;
                end
                else if (stat.del_ok)
                begin
                    cmd.del_rd = 1'b1;
                    state_next = S_DELW;
                end
                else
                begin
                    state_next = S_DIVGO;
                end
            end
            S_SHIFT:
            begin
                if (stat.ptr_above)
                begin
                    cmd.shift_rd = 1'b1;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DIVGO;
            end
            S_DELW:
            begin
                cmd.del_upd = 1'b1;
                state_next  = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVRUN;
            end
            S_DIVRUN:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the ordered record list. A directed run covers
// empty, full and out-of-range cases, then a random run alternates between
// filling and draining the list. Each accepted item is applied to a local
// copy of the list, and each returned status, count and mean mark is checked
// in order against it, under several patterns of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;

    typedef struct packed {
        orl_pkg::op_t   op;
        orl_pkg::pos_t  pos;
        orl_pkg::id_t   id;
        orl_pkg::mark_t mark;
    } list_cmd_t;

    typedef struct packed {
        orl_pkg::status_t     status;
        orl_pkg::count_port_t count;
        orl_pkg::avg_t        avg;
    } list_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    orl_pkg::op_t         operation     = orl_pkg::OP_QUERY;
    orl_pkg::pos_t        position      = '0;
    orl_pkg::id_t         entry_id      = '0;
    orl_pkg::mark_t       entry_marks   = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    orl_pkg::status_t     status;
    orl_pkg::count_port_t entry_count;
    orl_pkg::avg_t        average_marks;

    list_cmd_t    pending_items[$];
    list_result_t expected_results[$];

    // Local copy of the list: marks only, front first; ids never reach an output.
    orl_pkg::mark_t held_marks[$];
    int unsigned    held_total   = 0;

    int           planned_count = 0;
    int           total_items   = 0;
    int           items_issued  = 0;
    int           mismatch_count = 0;
    int           quiet_cycles  = 0;

    ordered_record_list uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .position      (position),
        .entry_id      (entry_id),
        .entry_marks   (entry_marks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_count   (entry_count),
        .average_marks (average_marks)
    );

    always #5 clk = ~clk;

    // Applies one operation to the local list and returns the result it gives.
    function automatic list_result_t apply_operation(list_cmd_t c);
        list_result_t r;
        int           held;
        held = held_marks.size();
        r.status = orl_pkg::ST_OK;
        case (c.op)
            orl_pkg::OP_INS_FRONT:
            begin
                if (held >= orl_pkg::DEPTH)
                    r.status = orl_pkg::ST_FULL;
                else
                begin
                    held_marks.push_front(c.mark);
                    held_total += c.mark;
                end
            end
            orl_pkg::OP_INS_POS:
            begin
                if (c.pos < 1 || c.pos > held + 1)
                    r.status = orl_pkg::ST_BADPOS;
                else if (held >= orl_pkg::DEPTH)
                    r.status = orl_pkg::ST_FULL;
                else
                begin
                    held_marks.insert(c.pos - 1, c.mark);
                    held_total += c.mark;
                end
            end
            orl_pkg::OP_DEL_LAST:
            begin
                if (held == 0)
                    r.status = orl_pkg::ST_EMPTY;
                else
                begin
                    held_total -= held_marks[held - 1];
                    void'(held_marks.pop_back());
                end
            end
            default:
            begin
                if (held == 0)
                    r.status = orl_pkg::ST_EMPTY;
            end
        endcase
        r.count = orl_pkg::count_port_t'(held_marks.size());
        if (held_marks.size() != 0)
            r.avg = orl_pkg::avg_t'(held_total / held_marks.size());
        else
            r.avg = '0;
        return r;
    endfunction

    // Queues an item and keeps track of the count it will leave behind, so that
    // the random part can aim positions at the live range.
    task automatic queue_item(orl_pkg::op_t op, orl_pkg::pos_t pos, orl_pkg::id_t id,
                              orl_pkg::mark_t mark);
        list_cmd_t c;
        c.op   = op;
        c.pos  = pos;
        c.id   = id;
        c.mark = mark;
        pending_items.push_back(c);
        case (op)
            orl_pkg::OP_INS_FRONT:
                if (planned_count < orl_pkg::DEPTH)
                    planned_count++;
            orl_pkg::OP_INS_POS:
                if (pos >= 1 && pos <= planned_count + 1 &&
                    planned_count < orl_pkg::DEPTH)
                    planned_count++;
            orl_pkg::OP_DEL_LAST:
                if (planned_count > 0)
                    planned_count--;
            default:
                ;
        endcase
    endtask

    function automatic orl_pkg::mark_t pick_mark();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return orl_pkg::mark_t'($urandom_range(0, 4095));
    endfunction

    // Idling pattern by stage of the run: none, sender gaps, receiver stalls,
    // both, and a clean stretch at the end.
    function automatic int idle_stage();
        if (total_items == 0)
            return 0;
        return (items_issued * 5) / total_items;
    endfunction

    function automatic int sender_idle_rate();
        case (idle_stage())
            1:       return 68;
            3:       return 29;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_rate();
        case (idle_stage())
            2:       return 68;
            3:       return 29;
            default: return 0;
        endcase
    endfunction

    always @(posedge clk)
    begin : drive
        list_cmd_t next_cmd;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                next_cmd.op   = operation;
                next_cmd.pos  = position;
                next_cmd.id   = entry_id;
                next_cmd.mark = entry_marks;
                expected_results.push_back(apply_operation(next_cmd));
                items_issued++;
            end
            // A stalled item is held as it is until it has been taken.
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_rate())
                begin
                    next_cmd    = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= next_cmd.op;
                    position    <= next_cmd.pos;
                    entry_id    <= next_cmd.id;
                    entry_marks <= next_cmd.mark;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : observe
        list_result_t want;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_rate());
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: status %0d count %0d average %0d",
                                 status, entry_count, average_marks);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || entry_count !== want.count ||
                        average_marks !== want.avg)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Mismatch: expected status %0d count %0d average %0d",
                                     want.status, want.count, want.avg);
                            $display("          got status %0d count %0d average %0d",
                                     status, entry_count, average_marks);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ordered_record_list test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        bit            filling;
        int            r;
        int            k;
        orl_pkg::pos_t p;

        // Directed part: empty list, bad positions, append, full list.
        queue_item(orl_pkg::OP_QUERY,     8'd0,   16'h0000, 12'h000);
        queue_item(orl_pkg::OP_DEL_LAST,  8'd0,   16'h1234, 12'hABC);
        queue_item(orl_pkg::OP_INS_POS,   8'd0,   16'h0001, 12'h010);
        queue_item(orl_pkg::OP_INS_POS,   8'd2,   16'h0002, 12'h020);
        queue_item(orl_pkg::OP_INS_POS,   8'd1,   16'hFFFF, 12'hFFF);
        queue_item(orl_pkg::OP_INS_FRONT, 8'hFF,  16'h0000, 12'h000);
        queue_item(orl_pkg::OP_INS_POS,   8'd3,   16'h5A5A, 12'h800);
        queue_item(orl_pkg::OP_INS_POS,   8'd255, 16'hA5A5, 12'h7FF);
        queue_item(orl_pkg::OP_QUERY,     8'hAA,  16'hFFFF, 12'hFFF);
        queue_item(orl_pkg::OP_DEL_LAST,  8'h55,  16'h0000, 12'h000);
        for (k = 0; planned_count < orl_pkg::DEPTH; k++)
        begin
            if (k % 2 == 0)
                queue_item(orl_pkg::OP_INS_FRONT, 8'd0, orl_pkg::id_t'(k), 12'hFFF);
            else
                queue_item(orl_pkg::OP_INS_POS, orl_pkg::pos_t'(planned_count + 1),
                           orl_pkg::id_t'(k), 12'hFFF);
        end
        queue_item(orl_pkg::OP_INS_FRONT, 8'd1,  16'hBEEF, 12'h123);
        queue_item(orl_pkg::OP_INS_POS,   8'd17, 16'hBEEF, 12'h123);
        queue_item(orl_pkg::OP_INS_POS,   8'd18, 16'hBEEF, 12'h123);
        queue_item(orl_pkg::OP_QUERY,     8'd0,  16'h0000, 12'h000);
        queue_item(orl_pkg::OP_DEL_LAST,  8'd0,  16'h0000, 12'h000);

        // Random part: swings between filling and draining so that both ends
        // of the list are reached again and again.
        filling = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (planned_count >= orl_pkg::DEPTH)
                filling = 1'b0;
            else if (planned_count == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 5)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (filling ? (r < 30) : (r < 10))
                queue_item(orl_pkg::OP_INS_FRONT, orl_pkg::pos_t'($urandom_range(0, 255)),
                           orl_pkg::id_t'($urandom_range(0, 65535)), pick_mark());
            else if (filling ? (r < 70) : (r < 25))
            begin
                case ($urandom_range(0, 9))
                    0:       p = '0;
                    1:       p = orl_pkg::pos_t'($urandom_range(planned_count + 2, 255));
                    2:       p = orl_pkg::pos_t'($urandom_range(0, 255));
                    default: p = orl_pkg::pos_t'($urandom_range(1, planned_count + 1));
                endcase
                queue_item(orl_pkg::OP_INS_POS, p,
                           orl_pkg::id_t'($urandom_range(0, 65535)), pick_mark());
            end
            else if (filling ? (r < 85) : (r < 80))
                queue_item(orl_pkg::OP_DEL_LAST, orl_pkg::pos_t'($urandom_range(0, 255)),
                           orl_pkg::id_t'($urandom_range(0, 65535)), pick_mark());
            else
                queue_item(orl_pkg::OP_QUERY, orl_pkg::pos_t'($urandom_range(0, 255)),
                           orl_pkg::id_t'($urandom_range(0, 65535)), pick_mark());
        end
        total_items = pending_items.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("ordered_record_list test passed");
        else
            $display("ordered_record_list test failed");
        $finish;
    end

endmodule
